@@ hdl/uctl_pkg.sv @@
`default_nettype none
package uctl_pkg;
    // input item modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_OUT   = 2'd1;
    localparam logic [1:0] MODE_IN    = 2'd2;
    localparam logic [1:0] MODE_ERR   = 2'd3;

    // result actions
    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_SETUP    = 3'd1;
    localparam logic [2:0] ACT_OUT_DATA = 3'd2;
    localparam logic [2:0] ACT_ARM_IN   = 3'd3;
    localparam logic [2:0] ACT_STAT_OUT = 3'd4;
    localparam logic [2:0] ACT_STAT_IN  = 3'd5;
    localparam logic [2:0] ACT_COMPLETE = 3'd6;

    // completion status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_OVERFLOW = 3'd1;
    localparam logic [2:0] ST_REMOTEIO = 3'd2;
    localparam logic [2:0] ST_PIPE     = 3'd3;
    localparam logic [2:0] ST_TIMEOUT  = 3'd4;
    localparam logic [2:0] ST_PROTO    = 3'd5;
    localparam logic [2:0] ST_NODEV    = 3'd6;
    localparam logic [2:0] ST_BUSY     = 3'd7;

    // error kinds reported with an error item
    localparam logic [3:0] ERR_NONE     = 4'd0;
    localparam logic [3:0] ERR_OVERRUN  = 4'd1;
    localparam logic [3:0] ERR_UNDERRUN = 4'd2;
    localparam logic [3:0] ERR_STALL    = 4'd3;
    localparam logic [3:0] ERR_TIMEOUT  = 4'd4;
    localparam logic [3:0] ERR_CRC      = 4'd5;
    localparam logic [3:0] ERR_TOGGLE   = 4'd6;
    localparam logic [3:0] ERR_PID      = 4'd7;

    localparam logic [6:0] SETUP_LEN = 7'd8;
    localparam logic [7:0] SPLIT_BIT = 8'h80;
    localparam logic [1:0] SPEED_LOW  = 2'd0;
    localparam logic [1:0] SPEED_HIGH = 2'd2;

    // classified item from front to back
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] transfer_length;
        logic        is_out_direction;
        logic [6:0]  packet_size;
        logic        short_not_ok;
        logic [7:0]  rx_count;
        logic [2:0]  err_status;
        logic [7:0]  addr_byte;
        logic [7:0]  port_byte;
    } cmd_t;

    // one result item
    typedef struct packed {
        logic [2:0]  action;
        logic [6:0]  packet_length;
        logic [7:0]  accept_count;
        logic [15:0] bytes_done;
        logic [2:0]  done_status;
        logic        overflow_flag;
        logic        short_error;
        logic        resend;
        logic        rejected;
        logic [7:0]  addr_byte;
        logic [7:0]  port_byte;
    } res_t;
endpackage
`default_nettype wire

@@ hdl/uctl_front.sv @@
`default_nettype none
module uctl_front #(
    parameter int MAX_PACKET_LIMIT = 64
) (
    input  wire logic [1:0]  mode,
    input  wire logic [15:0] transfer_length,
    input  wire logic        is_out_direction,
    input  wire logic [6:0]  max_packet,
    input  wire logic        short_not_ok,
    input  wire logic [7:0]  rx_count,
    input  wire logic [3:0]  error_kind,
    input  wire logic [6:0]  dev_address,
    input  wire logic [6:0]  port_number,
    input  wire logic [1:0]  speed,
    input  wire logic        via_hub,
    input  wire logic        shutting_down,
    output uctl_pkg::cmd_t   cmd
);
    localparam logic [6:0] PKT_MAX = 7'(MAX_PACKET_LIMIT);

    always_comb
    begin
        cmd = '0;
        cmd.mode             = mode;
        cmd.transfer_length  = transfer_length;
        cmd.is_out_direction = is_out_direction;
        cmd.short_not_ok     = short_not_ok;
        cmd.rx_count         = rx_count;
        // clamp packet size
        if (max_packet < 7'd8)
            cmd.packet_size = 7'd8;
        else if (max_packet > PKT_MAX)
            cmd.packet_size = PKT_MAX;
        else
            cmd.packet_size = max_packet;
        // split flags
        cmd.addr_byte = {1'b0, dev_address};
        cmd.port_byte = {1'b0, port_number};
        if (via_hub && speed != uctl_pkg::SPEED_HIGH)
            cmd.addr_byte = cmd.addr_byte | uctl_pkg::SPLIT_BIT;
        if (via_hub && speed == uctl_pkg::SPEED_LOW)
            cmd.port_byte = cmd.port_byte | uctl_pkg::SPLIT_BIT;
        // map error kind
        case (error_kind)
            uctl_pkg::ERR_NONE, uctl_pkg::ERR_OVERRUN:
                cmd.err_status = uctl_pkg::ST_OVERFLOW;
            uctl_pkg::ERR_UNDERRUN:
                cmd.err_status = uctl_pkg::ST_REMOTEIO;
            uctl_pkg::ERR_STALL:
                cmd.err_status = uctl_pkg::ST_PIPE;
            uctl_pkg::ERR_TIMEOUT:
                cmd.err_status = uctl_pkg::ST_TIMEOUT;
            uctl_pkg::ERR_CRC, uctl_pkg::ERR_TOGGLE, uctl_pkg::ERR_PID:
                cmd.err_status = uctl_pkg::ST_PROTO;
            default:
                cmd.err_status = uctl_pkg::ST_PIPE;
        endcase
        if (shutting_down)
            cmd.err_status = uctl_pkg::ST_NODEV;
    end
endmodule
`default_nettype wire

@@ hdl/uctl_queue.sv @@
`default_nettype none
module uctl_queue #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic [W-1:0] in_data,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic [W-1:0]      out_data
);
    // two-entry queue: main and skid
    logic         main_v_reg, skid_v_reg;
    logic [W-1:0] main_reg, skid_reg;

    assign out_valid = main_v_reg;
    assign out_data  = main_reg;
    assign in_stall  = skid_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            if (!main_v_reg || !out_stall)
            begin
                main_v_reg <= skid_v_reg || in_valid;
                skid_v_reg <= 1'b0;
            end
            else if (in_valid && !skid_v_reg)
                skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_v_reg || !out_stall)
            main_reg <= skid_v_reg ? skid_reg : in_data;
        if (in_valid && !skid_v_reg)
            skid_reg <= in_data;
    end
endmodule
`default_nettype wire

@@ hdl/uctl_back.sv @@
`default_nettype none
module uctl_back (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cmd_valid,
    output logic          cmd_stall,
    input  uctl_pkg::cmd_t cmd,
    output logic          res_valid,
    input  wire logic     res_stall,
    output uctl_pkg::res_t res
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SETUP  = 3'd1;
    localparam logic [2:0] S_OUT    = 3'd2;
    localparam logic [2:0] S_IN     = 3'd3;
    localparam logic [2:0] S_STATUS = 3'd4;

    logic [2:0]  stage_reg, stage_next;
    logic [15:0] total_reg, total_next, done_reg, done_next;
    logic [6:0]  last_reg, last_next, psize_reg, psize_next;
    logic        dir_reg, dir_next, sforb_reg, sforb_next;
    logic        ovf_reg, ovf_next, sseen_reg, sseen_next;
    logic        rv_reg;
    uctl_pkg::res_t r_reg, r_next;
    logic        go;
    logic [15:0] rem, sum_out, sum_in;
    logic [6:0]  out_len;
    logic [7:0]  acc;
    logic [2:0]  norm_st;

    assign res_valid = rv_reg;
    assign res       = r_reg;
    assign cmd_stall = rv_reg && res_stall;
    assign go        = cmd_valid && !cmd_stall;

    always_comb
    begin
        rem     = total_reg - done_reg;
        out_len = ({9'd0, psize_reg} < rem) ? psize_reg : rem[6:0];
        sum_out = done_reg + {9'd0, last_reg};
        acc     = ({8'd0, cmd.rx_count} > rem) ? rem[7:0] : cmd.rx_count;
        sum_in  = done_reg + {8'd0, acc};
        norm_st = ovf_reg ? uctl_pkg::ST_OVERFLOW
                : (sseen_reg ? uctl_pkg::ST_REMOTEIO : uctl_pkg::ST_OK);
    end

    // step the transfer
    always_comb
    begin
        stage_next = stage_reg; total_next = total_reg; done_next = done_reg;
        last_next = last_reg; psize_next = psize_reg; dir_next = dir_reg;
        sforb_next = sforb_reg; ovf_next = ovf_reg; sseen_next = sseen_reg;
        r_next = '0;
        case (cmd.mode)
            uctl_pkg::MODE_START:
            begin
                r_next.addr_byte = cmd.addr_byte;
                r_next.port_byte = cmd.port_byte;
                if (stage_reg != S_IDLE)
                begin
                    r_next.rejected    = 1'b1;
                    r_next.done_status = uctl_pkg::ST_BUSY;
                end
                else
                begin
                    total_next = cmd.transfer_length;
                    dir_next   = cmd.is_out_direction;
                    psize_next = cmd.packet_size;
                    sforb_next = cmd.short_not_ok;
                    done_next  = '0; last_next = '0;
                    ovf_next   = 1'b0; sseen_next = 1'b0;
                    stage_next = S_SETUP;
                    r_next.action        = uctl_pkg::ACT_SETUP;
                    r_next.packet_length = uctl_pkg::SETUP_LEN;
                end
            end
            uctl_pkg::MODE_OUT:
            begin
                if (stage_reg == S_SETUP)
                begin
                    if (total_reg == done_reg)
                    begin
                        stage_next = S_STATUS;
                        r_next.action = uctl_pkg::ACT_STAT_IN;
                    end
                    else if (dir_reg)
                    begin
                        last_next = out_len; stage_next = S_OUT;
                        r_next.action = uctl_pkg::ACT_OUT_DATA;
                        r_next.packet_length = out_len;
                    end
                    else
                    begin
                        stage_next = S_IN;
                        r_next.action = uctl_pkg::ACT_ARM_IN;
                    end
                end
                else if (stage_reg == S_OUT)
                begin
                    done_next = sum_out;
                    if (sum_out >= total_reg)
                    begin
                        stage_next = S_STATUS;
                        r_next.action = uctl_pkg::ACT_STAT_IN;
                    end
                    else
                    begin
                        // length from the advanced count
                        last_next = ({9'd0, psize_reg} < (total_reg - sum_out))
                                  ? psize_reg : 7'(total_reg - sum_out);
                        r_next.action = uctl_pkg::ACT_OUT_DATA;
                        r_next.packet_length = last_next;
                    end
                end
                else if (stage_reg == S_STATUS)
                begin
                    stage_next = S_IDLE;
                    r_next.action = uctl_pkg::ACT_COMPLETE;
                    r_next.done_status = norm_st;
                end
            end
            uctl_pkg::MODE_IN:
            begin
                if (stage_reg == S_IN)
                begin
                    if ({8'd0, cmd.rx_count} > rem)
                    begin
                        ovf_next = 1'b1;
                        r_next.overflow_flag = 1'b1;
                    end
                    r_next.accept_count = acc;
                    done_next = sum_in;
                    if (sum_in >= total_reg)
                    begin
                        stage_next = S_STATUS;
                        r_next.action = uctl_pkg::ACT_STAT_OUT;
                    end
                    else if ({1'b0, cmd.rx_count} < {2'b0, psize_reg})
                    begin
                        if (sforb_reg)
                        begin
                            sseen_next = 1'b1;
                            r_next.short_error = 1'b1;
                        end
                        stage_next = S_STATUS;
                        r_next.action = uctl_pkg::ACT_STAT_OUT;
                    end
                    else
                        r_next.action = uctl_pkg::ACT_ARM_IN;
                end
                else if (stage_reg == S_STATUS)
                begin
                    stage_next = S_IDLE;
                    r_next.action = uctl_pkg::ACT_COMPLETE;
                    r_next.done_status = norm_st;
                end
            end
            default:
            begin
                if (stage_reg != S_IDLE)
                begin
                    stage_next = S_IDLE;
                    r_next.action = uctl_pkg::ACT_COMPLETE;
                    r_next.done_status = cmd.err_status;
                    r_next.resend = (cmd.err_status == uctl_pkg::ST_PIPE)
                                 || (cmd.err_status == uctl_pkg::ST_NODEV);
                end
            end
        endcase
        r_next.bytes_done = done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= S_IDLE; total_reg <= '0; done_reg <= '0;
            last_reg <= '0; psize_reg <= 7'd64; dir_reg <= 1'b0;
            sforb_reg <= 1'b0; ovf_reg <= 1'b0; sseen_reg <= 1'b0;
            rv_reg <= 1'b0;
        end
        else
        begin
            if (go)
            begin
                stage_reg <= stage_next; total_reg <= total_next;
                done_reg <= done_next; last_reg <= last_next;
                psize_reg <= psize_next; dir_reg <= dir_next;
                sforb_reg <= sforb_next; ovf_reg <= ovf_next;
                sseen_reg <= sseen_next;
            end
            if (!cmd_stall)
                rv_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
            r_reg <= r_next;
    end
endmodule
`default_nettype wire

@@ hdl/usb_control_transfer_sequencer.sv @@
// USB control transfer sequencer, host side, endpoint zero.
// Input channel: in_valid/in_stall carry one event item (start, out-done,
// in-done, error) with its fields; the front classifies it (packet size
// clamp, split flags, error status) and writes it into a two-entry queue.
// The back pops one item per cycle while out_stall is low, steps the
// transfer state and writes one result item into an output register,
// shown on out_valid/out_stall. An accepted item passes through the queue's
// main entry and then the output register before out_valid rises.
// Throughput: one item per cycle while out_stall is low.
// When the receiver stalls, the output holds and the queue fills; once both
// queue entries are taken in_stall rises, so no item is lost.
// Reset (rst_n low, asynchronous) empties the queue and the output, sets
// the sequencer idle with packet size 64, and clears shutting_down.
// Configuration: register 0 (address 0) is shutting_down, bit 0; write only
// while the block is idle. pready is always high.
`default_nettype none
module usb_control_transfer_sequencer #(
    parameter int MAX_PACKET_LIMIT = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [15:0] transfer_length,
    input  wire logic        is_out_direction,
    input  wire logic [6:0]  max_packet,
    input  wire logic        short_not_ok,
    input  wire logic [7:0]  rx_count,
    input  wire logic [3:0]  error_kind,
    input  wire logic [6:0]  dev_address,
    input  wire logic [6:0]  port_number,
    input  wire logic [1:0]  speed,
    input  wire logic        via_hub,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       action,
    output logic [6:0]       packet_length,
    output logic [7:0]       accept_count,
    output logic [15:0]      bytes_done,
    output logic [2:0]       done_status,
    output logic             overflow_flag,
    output logic             short_error,
    output logic             resend,
    output logic             rejected,
    output logic [7:0]       addr_byte,
    output logic [7:0]       port_byte
);
    logic           shut_reg;
    uctl_pkg::cmd_t fcmd, qcmd;
    uctl_pkg::res_t res;
    logic           q_valid, q_stall;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {31'd0, shut_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            shut_reg <= 1'b0;
        else if (psel && penable && pwrite && paddr == 1'b0)
            shut_reg <= pwdata[0];
    end

    uctl_front #(.MAX_PACKET_LIMIT(MAX_PACKET_LIMIT)) u_front (
        .mode(mode), .transfer_length(transfer_length),
        .is_out_direction(is_out_direction), .max_packet(max_packet),
        .short_not_ok(short_not_ok), .rx_count(rx_count),
        .error_kind(error_kind), .dev_address(dev_address),
        .port_number(port_number), .speed(speed), .via_hub(via_hub),
        .shutting_down(shut_reg), .cmd(fcmd)
    );

    uctl_queue #(.W($bits(uctl_pkg::cmd_t))) u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(fcmd),
        .out_valid(q_valid), .out_stall(q_stall), .out_data(qcmd)
    );

    uctl_back u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(q_valid), .cmd_stall(q_stall), .cmd(qcmd),
        .res_valid(out_valid), .res_stall(out_stall), .res(res)
    );

    assign action        = res.action;
    assign packet_length = res.packet_length;
    assign accept_count  = res.accept_count;
    assign bytes_done    = res.bytes_done;
    assign done_status   = res.done_status;
    assign overflow_flag = res.overflow_flag;
    assign short_error   = res.short_error;
    assign resend        = res.resend;
    assign rejected      = res.rejected;
    assign addr_byte     = res.addr_byte;
    assign port_byte     = res.port_byte;
endmodule
`default_nettype wire
